// File: rtl/tfn_pkg.sv
// Shared types, widths and step functions for the triangle face normal core.
// Used by tfn_front, tfn_queue, tfn_back and the top level.
package tfn_pkg;

    localparam int MAG_W      = 31;
    localparam int SUM_W      = 64;
    localparam int WIDE_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int NORM_STEPS = 6;
    localparam int SQ_STEPS   = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    typedef logic [2:0][MAG_W-1:0] mag3_t;

    typedef struct packed {
        mag3_t      mag;
        logic [2:0] neg;
        logic       deg;
    } pay_t;

    typedef struct packed {
        pay_t             pay;
        logic [SUM_W-1:0] sum;
    } tfn_item_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [ROOT_W-1:0] r;
        logic              qbit;
    } dv_t;

    function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem_in,
                                      input logic [ROOT_W-1:0] root_in,
                                      input logic [1:0] pair);
        logic [REM_W-1:0] rem_s;
        logic [REM_W-1:0] trial;
        sq_t              res;
        rem_s = {rem_in[REM_W-3:0], pair};
        trial = REM_W'({root_in, 2'b01});
        if (rem_s >= trial)
        begin
            res.rem  = rem_s - trial;
            res.root = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_s;
            res.root = {root_in[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic dv_t div_step(input logic [ROOT_W-1:0] r_in,
                                     input logic nbit,
                                     input logic [ROOT_W-1:0] len);
        logic [ROOT_W:0] rs;
        logic [ROOT_W:0] d;
        dv_t             res;
        rs = {r_in, nbit};
        d  = {1'b0, len};
        if (rs >= d)
        begin
            res.r    = ROOT_W'(rs - d);
            res.qbit = 1'b1;
        end
        else
        begin
            res.r    = ROOT_W'(rs);
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// File: rtl/tfn_front.sv
// Front pipeline: edges, cross product, sign and degenerate classification,
// magnitude scaling and sum of squares. Depends on tfn_pkg.
module tfn_front
    import tfn_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_push,
    input  logic signed [2:0][COORD_BITS-1:0] v0,
    input  logic signed [2:0][COORD_BITS-1:0] v1,
    input  logic signed [2:0][COORD_BITS-1:0] v2,
    output logic                              out_valid,
    output tfn_item_t                         out_item
);

    localparam int CW1 = COORD_BITS + 1;
    localparam int EW  = (CW1 > 31) ? 31 : CW1;
    localparam int PRE = CW1 - EW;
    localparam int PW  = 2 * EW;
    localparam int CRW = PW + 1;
    localparam int SQW = 2 * MAG_W;
    localparam int FS  = 6 + NORM_STEPS;
    localparam int SIDE_N = FS - 3;

    logic [FS-1:0]               vld_reg;
    logic signed [EW-1:0]        e1_reg [3];
    logic signed [EW-1:0]        e2_reg [3];
    logic signed [EW-1:0]        e1_next [3];
    logic signed [EW-1:0]        e2_next [3];
    logic signed [CW1-1:0]       d1 [3];
    logic signed [CW1-1:0]       d2 [3];
    logic signed [PW-1:0]        p_reg [6];
    logic signed [PW-1:0]        p_next [6];
    logic signed [CRW-1:0]       c_reg [3];
    logic signed [CRW-1:0]       c_next [3];
    logic signed [CRW-1:0]       ab [3];
    logic [2:0][WIDE_W-1:0]      mag_reg;
    logic [2:0][WIDE_W-1:0]      mag_next;
    logic [2:0][WIDE_W-1:0]      nm_reg [NORM_STEPS];
    logic [2:0][WIDE_W-1:0]      nm_next [NORM_STEPS];
    logic [2:0][WIDE_W-1:0]      nm_src [NORM_STEPS];
    logic [WIDE_W-1:0]           nm_or [NORM_STEPS];
    logic [3:0]                  side_reg [SIDE_N];
    logic [3:0]                  side_next;
    logic [2:0][SQW-1:0]         sq_reg;
    logic [2:0][SQW-1:0]         sq_next;
    mag3_t                       mh_reg;
    mag3_t                       mh_next;
    tfn_item_t                   item_reg;
    tfn_item_t                   item_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = CW1'($signed(v1[i])) - CW1'($signed(v0[i]));
            d2[i] = CW1'($signed(v2[i])) - CW1'($signed(v0[i]));
            e1_next[i] = EW'(d1[i] >>> PRE);
            e2_next[i] = EW'(d2[i] >>> PRE);
        end
        p_next[0] = PW'(e1_reg[1]) * PW'(e2_reg[2]);
        p_next[1] = PW'(e1_reg[2]) * PW'(e2_reg[1]);
        p_next[2] = PW'(e1_reg[2]) * PW'(e2_reg[0]);
        p_next[3] = PW'(e1_reg[0]) * PW'(e2_reg[2]);
        p_next[4] = PW'(e1_reg[0]) * PW'(e2_reg[1]);
        p_next[5] = PW'(e1_reg[1]) * PW'(e2_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            c_next[i] = CRW'(p_reg[2*i]) - CRW'(p_reg[2*i+1]);
            ab[i] = c_reg[i][CRW-1] ? -c_reg[i] : c_reg[i];
            mag_next[i] = WIDE_W'($unsigned(ab[i]));
        end
        side_next = {c_reg[2][CRW-1], c_reg[1][CRW-1], c_reg[0][CRW-1],
                     (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0)};
        for (int k = 0; k < NORM_STEPS; k++)
        begin
            nm_src[k] = (k == 0) ? mag_reg : nm_reg[(k == 0) ? 0 : k - 1];
            nm_or[k]  = nm_src[k][0] | nm_src[k][1] | nm_src[k][2];
            nm_next[k] = nm_src[k];
            if (k < NORM_STEPS - 1)
            begin
                if ((nm_or[k] >> (31 + (1 << (NORM_STEPS - 2 - k)))) != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        nm_next[k][i] = nm_src[k][i] >> (1 << (NORM_STEPS - 2 - k));
                end
            end
            else
            begin
                if ((nm_or[k] >> 31) != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        nm_next[k][i] = nm_src[k][i] >> 1;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            mh_next[i] = nm_reg[NORM_STEPS-1][i][MAG_W-1:0];
            sq_next[i] = SQW'(mh_next[i]) * SQW'(mh_next[i]);
        end
        item_next.pay.mag = mh_reg;
        item_next.pay.neg = side_reg[SIDE_N-2][3:1];
        item_next.pay.deg = side_reg[SIDE_N-2][0];
        item_next.sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[FS-2:0], in_push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            p_reg    <= p_next;
            c_reg    <= c_next;
            mag_reg  <= mag_next;
            nm_reg   <= nm_next;
            sq_reg   <= sq_next;
            mh_reg   <= mh_next;
            item_reg <= item_next;
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_N; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = vld_reg[FS-1];
    assign out_item  = item_reg;

endmodule

// File: rtl/tfn_queue.sv
// Short item queue between front and back pipelines.
// Depends on tfn_pkg for the item type and depth.
module tfn_queue
    import tfn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  tfn_item_t wr_item,
    input  logic      rd,
    output logic      room,
    output logic      avail,
    output tfn_item_t head
);

    tfn_item_t       slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg;
    logic [Q_AW-1:0] rp_reg;
    logic [Q_AW:0]   cnt_reg;
    logic [Q_AW:0]   cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
            cnt_next = cnt_reg + 1'b1;
        else if (rd && !wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wp_reg] <= wr_item;
    end

    assign room  = (cnt_reg < (Q_AW+1)'(Q_DEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = slot_reg[rp_reg];

endmodule

// File: rtl/tfn_back.sv
// Back pipeline: square root, per-component division, sign and output buffer.
// Depends on tfn_pkg.
module tfn_back
    import tfn_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 15
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_avail,
    input  tfn_item_t                        in_item,
    output logic                             in_take,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [NORMAL_FRAC_BITS+1:0] nx,
    output logic signed [NORMAL_FRAC_BITS+1:0] ny,
    output logic signed [NORMAL_FRAC_BITS+1:0] nz,
    output logic                             deg
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int OW = F + 2;
    localparam int QW = F + 1;
    localparam int NW = F + MAG_W + 1;
    localparam int DV = F + 1;
    localparam int BS = SQ_STEPS + 1 + DV;

    logic                  adv;
    logic [BS-1:0]         bv_reg;
    logic [REM_W-1:0]      sq_rem_reg [SQ_STEPS];
    logic [ROOT_W-1:0]     sq_root_reg [SQ_STEPS];
    logic [SUM_W-1:0]      sq_x_reg [SQ_STEPS];
    pay_t                  sq_pay_reg [SQ_STEPS];
    sq_t                   sq_st [SQ_STEPS];
    logic [REM_W-1:0]      sq_rin [SQ_STEPS];
    logic [ROOT_W-1:0]     sq_oin [SQ_STEPS];
    logic [SUM_W-1:0]      sq_xin [SQ_STEPS];
    pay_t                  sq_pin [SQ_STEPS];
    logic [2:0][NW-1:0]    pr_n_reg;
    logic [2:0][NW-1:0]    pr_n_next;
    logic [ROOT_W-1:0]     pr_len_reg;
    logic [ROOT_W-1:0]     pr_len_next;
    logic [3:0]            pr_side_reg;
    logic [2:0][ROOT_W-1:0] dv_r_reg [DV];
    logic [2:0][ROOT_W-1:0] dv_r_next [DV];
    logic [2:0][QW-1:0]    dv_q_reg [DV];
    logic [2:0][QW-1:0]    dv_q_next [DV];
    logic [2:0][NW-1:0]    dv_n_reg [DV];
    logic [2:0][NW-1:0]    dv_n_in [DV];
    logic [2:0][ROOT_W-1:0] dv_r_in [DV];
    logic [2:0][QW-1:0]    dv_q_in [DV];
    logic [ROOT_W-1:0]     dv_len_reg [DV];
    logic [ROOT_W-1:0]     dv_len_in [DV];
    logic [3:0]            dv_side_reg [DV];
    logic [3:0]            dv_side_in [DV];
    dv_t                   dv_st [DV][3];
    logic [QW-1:0]         qc [3];
    logic [OW-1:0]         res [3];
    logic                  push_out;
    logic                  pop_ok;
    logic [OW-1:0]         ob_x_reg [2];
    logic [OW-1:0]         ob_y_reg [2];
    logic [OW-1:0]         ob_z_reg [2];
    logic                  ob_d_reg [2];
    logic [1:0]            ob_cnt_reg;
    logic                  widx;

    assign adv     = (ob_cnt_reg != 2'd2);
    assign in_take = adv && in_avail;

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                sq_rin[k] = '0;
                sq_oin[k] = '0;
                sq_xin[k] = in_item.sum;
                sq_pin[k] = in_item.pay;
            end
            else
            begin
                sq_rin[k] = sq_rem_reg[k-1];
                sq_oin[k] = sq_root_reg[k-1];
                sq_xin[k] = sq_x_reg[k-1];
                sq_pin[k] = sq_pay_reg[k-1];
            end
            sq_st[k] = sqrt_step(sq_rin[k], sq_oin[k],
                                 sq_xin[k][2*(SQ_STEPS-1-k) +: 2]);
        end
        pr_len_next = (sq_root_reg[SQ_STEPS-1] == '0) ? ROOT_W'(1)
                                                      : sq_root_reg[SQ_STEPS-1];
        for (int i = 0; i < 3; i++)
            pr_n_next[i] = (NW'(sq_pay_reg[SQ_STEPS-1].mag[i]) << F)
                         + NW'(pr_len_next >> 1);
        for (int j = 0; j < DV; j++)
        begin
            if (j == 0)
            begin
                dv_n_in[j]    = pr_n_reg;
                dv_len_in[j]  = pr_len_reg;
                dv_side_in[j] = pr_side_reg;
                for (int i = 0; i < 3; i++)
                begin
                    dv_r_in[j][i] = ROOT_W'(pr_n_reg[i][NW-1:F+1]);
                    dv_q_in[j][i] = '0;
                end
            end
            else
            begin
                dv_n_in[j]    = dv_n_reg[j-1];
                dv_len_in[j]  = dv_len_reg[j-1];
                dv_side_in[j] = dv_side_reg[j-1];
                dv_r_in[j]    = dv_r_reg[j-1];
                dv_q_in[j]    = dv_q_reg[j-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                dv_st[j][i] = div_step(dv_r_in[j][i], dv_n_in[j][i][F-j], dv_len_in[j]);
                dv_r_next[j][i] = dv_st[j][i].r;
                dv_q_next[j][i] = {dv_q_in[j][i][QW-2:0], dv_st[j][i].qbit};
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (dv_q_reg[DV-1][i] > (QW'(1) << F)) ? (QW'(1) << F)
                                                        : dv_q_reg[DV-1][i];
            if (dv_side_reg[DV-1][0])
                res[i] = '0;
            else if (dv_side_reg[DV-1][i+1])
                res[i] = -OW'(qc[i]);
            else
                res[i] = OW'(qc[i]);
        end
    end

    assign push_out = adv && bv_reg[BS-1];
    assign pop_ok   = pop && (ob_cnt_reg != 2'd0);
    assign widx     = (ob_cnt_reg == 2'd2) || ((ob_cnt_reg == 2'd1) && !pop_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg     <= '0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            if (adv)
                bv_reg <= {bv_reg[BS-2:0], in_take};
            ob_cnt_reg <= ob_cnt_reg + {1'b0, push_out} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_rem_reg[k]  <= sq_st[k].rem;
                sq_root_reg[k] <= sq_st[k].root;
                sq_x_reg[k]    <= sq_xin[k];
                sq_pay_reg[k]  <= sq_pin[k];
            end
            pr_n_reg    <= pr_n_next;
            pr_len_reg  <= pr_len_next;
            pr_side_reg <= {sq_pay_reg[SQ_STEPS-1].neg, sq_pay_reg[SQ_STEPS-1].deg};
            for (int j = 0; j < DV; j++)
            begin
                dv_r_reg[j]    <= dv_r_next[j];
                dv_q_reg[j]    <= dv_q_next[j];
                dv_n_reg[j]    <= dv_n_in[j];
                dv_len_reg[j]  <= dv_len_in[j];
                dv_side_reg[j] <= dv_side_in[j];
            end
        end
        if (pop_ok && !(push_out && !widx))
        begin
            ob_x_reg[0] <= ob_x_reg[1];
            ob_y_reg[0] <= ob_y_reg[1];
            ob_z_reg[0] <= ob_z_reg[1];
            ob_d_reg[0] <= ob_d_reg[1];
        end
        if (push_out)
        begin
            ob_x_reg[widx] <= res[0];
            ob_y_reg[widx] <= res[1];
            ob_z_reg[widx] <= res[2];
            ob_d_reg[widx] <= dv_side_reg[DV-1][0];
        end
    end

    assign empty = (ob_cnt_reg == 2'd0);
    assign nx    = ob_x_reg[0];
    assign ny    = ob_y_reg[0];
    assign nz    = ob_z_reg[0];
    assign deg   = ob_d_reg[0];

endmodule

// File: rtl/triangle_face_normal_core.sv
// Triangle face normal core: top level joining front, queue and back.
// Throughput: one item per cycle while the queue has room and the output is
// popped; every stage is a register, the 32-step square root and the
// NORMAL_FRAC_BITS + 1 step divider are fully pipelined.
// Reset: asynchronous, clears all valid bits and queue counts; full and empty
// show an idle block right after reset.
module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 15
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [COORD_BITS-1:0]       v0_x,
    input  logic signed [COORD_BITS-1:0]       v0_y,
    input  logic signed [COORD_BITS-1:0]       v0_z,
    input  logic signed [COORD_BITS-1:0]       v1_x,
    input  logic signed [COORD_BITS-1:0]       v1_y,
    input  logic signed [COORD_BITS-1:0]       v1_z,
    input  logic signed [COORD_BITS-1:0]       v2_x,
    input  logic signed [COORD_BITS-1:0]       v2_y,
    input  logic signed [COORD_BITS-1:0]       v2_z,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
    output logic                               degenerate
);

    logic      q_room;
    logic      q_avail;
    logic      q_take;
    logic      f_valid;
    tfn_item_t f_item;
    tfn_item_t q_head;

    assign full = !q_room;

    tfn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (q_room),
        .in_push   (push && q_room),
        .v0        ({v0_z, v0_y, v0_x}),
        .v1        ({v1_z, v1_y, v1_x}),
        .v2        ({v2_z, v2_y, v2_x}),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    tfn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_valid && q_room),
        .wr_item (f_item),
        .rd      (q_take),
        .room    (q_room),
        .avail   (q_avail),
        .head    (q_head)
    );

    tfn_back #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_avail (q_avail),
        .in_item  (q_head),
        .in_take  (q_take),
        .empty    (empty),
        .pop      (pop),
        .nx       (normal_x),
        .ny       (normal_y),
        .nz       (normal_z),
        .deg      (degenerate)
    );

endmodule

// File: rtl/tfn_checker.sv
// Port-level checks for triangle_face_normal_core, bound to the top level.
// Depends only on the top level's ports.
module tfn_checker #(
    parameter int NORMAL_FRAC_BITS = 15
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    input logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    input logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
    input logic                               degenerate
);

    localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE_P =
        (NORMAL_FRAC_BITS+2)'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [NORMAL_FRAC_BITS+1:0] ONE_N = -ONE_P;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate item with nonzero normal");

    a_live_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !degenerate) |-> (normal_x != '0 || normal_y != '0 || normal_z != '0))
        else $error("nondegenerate item with zero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (normal_x <= ONE_P && normal_x >= ONE_N
                 && normal_y <= ONE_P && normal_y >= ONE_N
                 && normal_z <= ONE_P && normal_z >= ONE_N))
        else $error("normal component out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(normal_x) && $stable(normal_y)
                              && $stable(normal_z) && $stable(degenerate)))
        else $error("waiting item changed");

endmodule

bind triangle_face_normal_core tfn_checker #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);

// File: test/tb_top.sv
// Self-checking testbench for triangle_face_normal_core: directed triangles from a
// table, then random ones, checked against table values or an in-bench predictor.
// Depends on tfn_pkg and the triangle_face_normal_core RTL.
module tb_top;

    localparam int CW        = 24;
    localparam int FW        = 15;
    localparam int NW        = FW + 2;
    localparam int N_RANDOM  = 1300;
    localparam int LIMIT     = 600000;
    localparam int DRAIN     = FW + 60;
    localparam int LONG_HOLD = 300;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] nrm_t;

    typedef struct packed {
        nrm_t nx;
        nrm_t ny;
        nrm_t nz;
        logic deg;
    } normal_t;

    typedef struct packed {
        logic [8:0][CW-1:0] v;
        logic               known;
        normal_t            exp;
    } tri_row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic empty;
    logic pop;
    nrm_t normal_x, normal_y, normal_z;
    logic degenerate;

    normal_t  pending_normals[$];
    tri_row_t tri_table[$];
    int       errors;
    int       n_pushed;
    int       n_popped;
    int       n_degen;
    int       cycles;
    bit       no_idle;
    bit       held_long;

    triangle_face_normal_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
        .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
        .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
        .empty(empty), .pop(pop),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic normal_t face_normal(input logic [8:0][CW-1:0] v);
        longint            e1[3];
        longint            e2[3];
        longint            c[3];
        longint unsigned   m[3];
        longint unsigned   mx, sum, len, res, bitv, q;
        int                s;
        normal_t           r;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = longint'(coord_t'(v[3+i])) - longint'(coord_t'(v[i]));
            e2[i] = longint'(coord_t'(v[6+i])) - longint'(coord_t'(v[i]));
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0)
        begin
            r.deg = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx)
                mx = m[i];
        end
        s = 0;
        while (s < 63 && (mx >> s) >= (64'd1 << 31))
            s++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = m[i] >> s;
            sum += m[i] * m[i];
        end
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > sum)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (sum >= res + bitv)
            begin
                sum = sum - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        len = (res == 0) ? 1 : res;
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FW) + (len >> 1)) / len;
            if (q > (64'd1 << FW))
                q = 64'd1 << FW;
            if (c[i] < 0)
                q = -q;
            case (i)
                0: r.nx = nrm_t'(q);
                1: r.ny = nrm_t'(q);
                default: r.nz = nrm_t'(q);
            endcase
        end
        return r;
    endfunction

    function automatic normal_t mk_normal(input int x, input int y, input int z, input logic d);
        normal_t r;
        r.nx  = nrm_t'(x);
        r.ny  = nrm_t'(y);
        r.nz  = nrm_t'(z);
        r.deg = d;
        return r;
    endfunction

    task automatic add_tri(input int a0, input int a1, input int a2,
                           input int b0, input int b1, input int b2,
                           input int c0, input int c1, input int c2,
                           input logic known, input normal_t exp);
        tri_row_t row;
        row.v     = {coord_t'(c2), coord_t'(c1), coord_t'(c0),
                     coord_t'(b2), coord_t'(b1), coord_t'(b0),
                     coord_t'(a2), coord_t'(a1), coord_t'(a0)};
        row.known = known;
        row.exp   = exp;
        tri_table.insert(tri_table.size(), row);
    endtask

    function automatic tri_row_t random_tri();
        tri_row_t  row;
        int        kind;
        int        k;
        int        span;
        kind = $urandom_range(0, 9);
        span = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++)
        begin
            if (kind < 5)
                row.v[i] = coord_t'($urandom());
            else if (span == 0)
                row.v[i] = coord_t'($signed($urandom_range(0, 15)) - 8);
            else
                row.v[i] = coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        end
        if (kind == 8)
        begin
            k = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++)
                row.v[6+i] = coord_t'(row.v[i] + k * (coord_t'(row.v[3+i]) - coord_t'(row.v[i])));
        end
        else if (kind == 9)
        begin
            k = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                row.v[3*k+i] = row.v[3*((k+1)%3)+i];
        end
        row.known = 1'b0;
        row.exp   = '0;
        return row;
    endfunction

    task automatic send_tri(input tri_row_t row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        {v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x} <= row.v;
        do @(posedge clk); while (full);
        pending_normals.insert(pending_normals.size(),
                               row.known ? row.exp : face_normal(row.v));
        n_pushed++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("unexpected item: normal=(%0d,%0d,%0d) degenerate=%0b",
                       normal_x, normal_y, normal_z, degenerate);
                errors++;
            end
            else
            begin
                normal_t e;
                e = pending_normals.pop_front();
                if (normal_x !== e.nx)
                begin
                    $error("normal_x expected %0d actual %0d", e.nx, normal_x);
                    errors++;
                end
                if (normal_y !== e.ny)
                begin
                    $error("normal_y expected %0d actual %0d", e.ny, normal_y);
                    errors++;
                end
                if (normal_z !== e.nz)
                begin
                    $error("normal_z expected %0d actual %0d", e.nz, normal_z);
                    errors++;
                end
                if (degenerate !== e.deg)
                begin
                    $error("degenerate expected %0b actual %0b", e.deg, degenerate);
                    errors++;
                end
            end
            n_popped++;
            if (degenerate)
                n_degen++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int gap;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_long && no_idle)
            begin
                held_long = 1'b1;
                gap = LONG_HOLD;
            end
            else
                gap = no_idle ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int max_c;
        int min_c;
        n_pushed = 0;
        no_idle  = 1'b0;
        rst_n    = 1'b0;
        push     = 1'b0;
        {v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x} = '0;
        max_c = (1 << (CW - 1)) - 1;
        min_c = -(1 << (CW - 1));

        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, mk_normal(0, 0, 0, 1'b1));
        add_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 1'b1, mk_normal(0, 0, 32768, 1'b0));
        add_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 1'b1, mk_normal(0, 0, -32768, 1'b0));
        add_tri(0, 0, 0, 0, 65536, 0, 0, 0, 65536, 1'b1, mk_normal(32768, 0, 0, 1'b0));
        add_tri(0, 0, 0, 0, 0, 65536, 65536, 0, 0, 1'b1, mk_normal(0, 32768, 0, 1'b0));
        add_tri(5, 7, 9, 100, 200, 300, 100, 200, 300, 1'b1, mk_normal(0, 0, 0, 1'b1));
        add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b1, mk_normal(0, 0, 0, 1'b1));
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1, mk_normal(0, 0, 32768, 1'b0));
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 1, 1'b1, mk_normal(0, -32768, 32768, 1'b0));
        add_tri(max_c, max_c, max_c, min_c, min_c, min_c, min_c, max_c, min_c,
                1'b0, '0);
        add_tri(min_c, min_c, min_c, max_c, min_c, min_c, min_c, max_c, min_c,
                1'b0, '0);
        add_tri(max_c, max_c, max_c, min_c, max_c, max_c, max_c, min_c, max_c,
                1'b0, '0);
        add_tri(min_c, max_c, min_c, max_c, min_c, max_c, min_c, min_c, max_c,
                1'b0, '0);
        add_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1, 1'b0, '0);
        add_tri(123456, -654321, 777, -5000000, 3000000, 8000000, 42, -42, 4242,
                1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tri_table[i])
            send_tri(tri_table[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            no_idle = (n >= 200 && n < 320) || (n >= 900 && n < 1000);
            if (n == 700)
            begin
                push <= 1'b0;
                while (pending_normals.size() != 0)
                    @(posedge clk);
            end
            send_tri(random_tri());
        end
        push <= 1'b0;

        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d triangles (%0d degenerate) with a long output stall",
                 n_pushed, n_degen);
        $display("and a full drain pause; %0d results checked", n_popped);
        if (errors == 0 && pending_normals.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
